FILE: src/sbt_pkg.sv
// ----------------------------------------------------------------------------
// Slot booking table package
// Shared status codes, modes, error codes and the entry evaluation type.
// ----------------------------------------------------------------------------
package sbt_pkg;

    // Width of the internal slot, day and run counters (holds 0..127).
    localparam int CNT_W = 7;

    localparam int DEF_MAX_SLOTS_PER_DAY = 32;
    localparam int DEF_MAX_DAYS          = 32;

    localparam int STATUS_W = 8;
    localparam int ID_W     = 64;
    localparam int ENTRY_W  = STATUS_W + ID_W;

    localparam logic [STATUS_W-1:0] ST_SCHEDULABLE = 8'd0;
    localparam logic [STATUS_W-1:0] ST_LOCKED      = 8'd1;
    localparam logic [STATUS_W-1:0] ST_BOOKED      = 8'd2;

    localparam logic [1:0] MODE_RESERVE  = 2'd0;
    localparam logic [1:0] MODE_FIND     = 2'd1;
    localparam logic [1:0] MODE_CLR_RNG  = 2'd2;
    localparam logic [1:0] MODE_CLR_ID   = 2'd3;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_SLOT      = 3'd1;
    localparam logic [2:0] ERR_COUNT     = 3'd2;
    localparam logic [2:0] ERR_NOT_FREE  = 3'd3;
    localparam logic [2:0] ERR_NOT_BOOK  = 3'd4;
    localparam logic [2:0] ERR_ID_ZERO   = 3'd5;
    localparam logic [2:0] ERR_DAY       = 3'd6;

    localparam logic [1:0] REG_SLOTS_PER_DAY = 2'd0;
    localparam logic [1:0] REG_DAYS_IN_USE   = 2'd1;

    // Result of looking at one stored entry.
    typedef struct packed {
        logic free;     // schedulable or locked
        logic booked;   // status is booked
        logic match;    // stored id matches the request id
    } sbt_eval_t;

endpackage

FILE: src/sbt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/sbt_eval.sv
// ----------------------------------------------------------------------------
// Entry evaluation unit
// Classifies one stored entry: free, booked, and whether its id matches.
// ----------------------------------------------------------------------------
module sbt_eval (
    input  logic [sbt_pkg::STATUS_W-1:0] status,
    input  logic [sbt_pkg::ID_W-1:0]     stored_id,
    input  logic [sbt_pkg::ID_W-1:0]     req_id,
    input  logic                         match_any,
    output sbt_pkg::sbt_eval_t           result
);

    always_comb
    begin
        result.free   = (status == sbt_pkg::ST_SCHEDULABLE) ||
                        (status == sbt_pkg::ST_LOCKED);
        result.booked = (status == sbt_pkg::ST_BOOKED);
        result.match  = match_any || (stored_id == req_id);
    end

endmodule

FILE: src/slot_booking_table.sv
// After reset a clearing pass over every table entry runs first.
// Reserve and clear range read and evaluate each slot on a check walk, then a write walk.
// Clear by id walks every table entry in use the same way; force skips the check walks.
// Find reads and evaluates each scanned slot of each day and emits one result per day;
// one memory port serves every walk. One request is worked at a time.
// Reset: asynchronous, active low; registers return to 32 and the table to schedulable/id 0.
// ----------------------------------------------------------------------------
// Slot booking table
// Day-by-slot booking store with reserve, find-free, clear-range and clear-by-id.
// ----------------------------------------------------------------------------
module slot_booking_table #(
    parameter int MAX_SLOTS_PER_DAY = sbt_pkg::DEF_MAX_SLOTS_PER_DAY,
    parameter int MAX_DAYS          = sbt_pkg::DEF_MAX_DAYS
) (
    input  logic         clk,
    input  logic         rst_n,
    // Configuration write port.
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [5:0]   cfg_data,
    // Request channel.
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata, from bit 0: day[5], end_day[6], slot[5], slot_end[6], count[6],
    // booking_id[64], clear_status[8], force_req[1], zero pad[3].
    input  logic [103:0] s_tdata,
    // s_tuser: mode[2].
    input  logic [1:0]   s_tuser,
    // Result channel.
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata, from bit 0: found_day[5], free_mask[32], zero pad[3].
    output logic [39:0]  m_tdata,
    // m_tuser: error[3].
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    localparam int DEPTH = MAX_DAYS * MAX_SLOTS_PER_DAY;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = sbt_pkg::CNT_W;

    // The sequencer walks the table one entry per read and one per evaluation.
    // CHK states run the status checks, WR states commit (all-or-nothing),
    // FND states build the free mask of one day, EMIT hands a result over.
    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_CHK_RD, S_CHK_EV, S_WR_RD, S_WR_EV, S_FND_RD, S_FND_EV, S_EMIT
    } state_t;

    state_t               state_reg;
    logic [1:0]           mode_reg;
    logic [63:0]          id_reg;
    logic [7:0]           cst_reg;
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        s1_reg;
    logic [CW-1:0]        slot_lo_reg;
    logic [CW-1:0]        slot_hi_reg;
    logic [CW-1:0]        day_hi_reg;
    logic [CW-1:0]        day_c_reg;
    logic [CW-1:0]        slot_c_reg;
    logic [CW-1:0]        run_reg;
    logic [31:0]          mask_reg;
    logic [2:0]           res_err_reg;
    logic [AW-1:0]        clr_addr_reg;
    logic [CW-1:0]        spd_reg;
    logic [CW-1:0]        days_reg;
    logic                 out_valid_reg;
    logic [2:0]           out_err_reg;
    logic [4:0]           out_day_reg;
    logic [31:0]          out_mask_reg;
    logic                 out_last_reg;

    // Request fields.
    logic [CW-1:0] in_day, in_eday, in_slot, in_s1, in_cnt;
    logic [63:0]   in_id;
    logic [7:0]    in_cst;
    logic          in_force;
    logic [2:0]    in_err;

    assign in_day   = CW'(s_tdata[4:0]);
    assign in_eday  = CW'(s_tdata[10:5]);
    assign in_slot  = CW'(s_tdata[15:11]);
    assign in_s1    = CW'(s_tdata[21:16]);
    assign in_cnt   = CW'(s_tdata[27:22]);
    assign in_id    = s_tdata[91:28];
    assign in_cst   = s_tdata[99:92];
    assign in_force = s_tdata[100];

    // Up-front range checks, in the order the block defines them.
    always_comb
    begin
        in_err = sbt_pkg::ERR_OK;
        unique case (s_tuser)
            sbt_pkg::MODE_FIND:
            begin
                if (in_cnt == '0 || in_cnt > spd_reg)
                    in_err = sbt_pkg::ERR_COUNT;
                else if (in_slot + in_cnt > spd_reg || in_s1 + in_cnt > spd_reg)
                    in_err = sbt_pkg::ERR_SLOT;
                else if (in_slot + in_cnt > in_s1)
                    in_err = sbt_pkg::ERR_COUNT;
                else if (in_eday > days_reg || in_day >= in_eday)
                    in_err = sbt_pkg::ERR_DAY;
            end
            sbt_pkg::MODE_CLR_ID:
            begin
                if (in_id == '0)
                    in_err = sbt_pkg::ERR_ID_ZERO;
            end
            default:
            begin
                if (in_slot >= spd_reg)
                    in_err = sbt_pkg::ERR_SLOT;
                else if (in_cnt == '0 || in_slot + in_cnt > spd_reg)
                    in_err = sbt_pkg::ERR_COUNT;
                else if (in_day >= days_reg)
                    in_err = sbt_pkg::ERR_DAY;
            end
        endcase
    end

    // Table memory: status in the top byte, booking id below.
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [sbt_pkg::ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]               walk_addr;
    logic [sbt_pkg::ENTRY_W-1:0] ram_rdata;

    assign walk_addr = AW'(day_c_reg * MAX_SLOTS_PER_DAY + slot_c_reg);

    sbt_ram #(
        .WIDTH (sbt_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (walk_addr),
        .rdata (ram_rdata)
    );

    sbt_pkg::sbt_eval_t ev;

    sbt_eval u_eval (
        .status    (ram_rdata[sbt_pkg::ENTRY_W-1 -: sbt_pkg::STATUS_W]),
        .stored_id (ram_rdata[sbt_pkg::ID_W-1:0]),
        .req_id    (id_reg),
        .match_any ((mode_reg == sbt_pkg::MODE_CLR_RNG) && (id_reg == '0)),
        .result    (ev)
    );

    // Commit write: reserve books every slot, clears release matching slots; reset pass zeroes all.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = walk_addr;
        ram_wdata = {sbt_pkg::ST_BOOKED, id_reg};
        if (state_reg == S_CLR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_WR_EV)
        begin
            if (mode_reg == sbt_pkg::MODE_RESERVE)
            begin
                ram_we = 1'b1;
            end
            else
            begin
                ram_we    = ev.match;
                ram_wdata = {cst_reg, 64'd0};
            end
        end
    end

    // Walk position bookkeeping.
    logic          slot_end, day_end, walk_done;
    logic          chk_fail;
    logic [CW-1:0] run_next;
    logic [CW-1:0] start;
    logic          find_ok;

    assign slot_end  = (slot_c_reg == slot_hi_reg);
    assign day_end   = (day_c_reg == day_hi_reg);
    assign walk_done = slot_end && day_end;
    assign chk_fail  = (mode_reg == sbt_pkg::MODE_RESERVE) ? !ev.free
                                                          : (ev.match && !ev.booked);
    assign run_next  = ev.free ? run_reg + CW'(1) : '0;
    assign start     = slot_c_reg - cnt_reg + CW'(1);
    assign find_ok   = (mode_reg == sbt_pkg::MODE_FIND) && (res_err_reg == sbt_pkg::ERR_OK);

    // Saturated register value.
    function automatic logic [CW-1:0] sat_cfg(input logic [5:0] v, input logic [CW-1:0] hi);
        logic [CW-1:0] r;
        r = CW'(v);
        if (r == '0)
            r = CW'(1);
        else if (r > hi)
            r = hi;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_addr_reg  <= '0;
            spd_reg       <= sat_cfg(6'd32, CW'(MAX_SLOTS_PER_DAY));
            days_reg      <= sat_cfg(6'd32, CW'(MAX_DAYS));
            out_valid_reg <= 1'b0;
            mode_reg      <= sbt_pkg::MODE_RESERVE;
            id_reg        <= '0;
            cst_reg       <= '0;
            cnt_reg       <= '0;
            s1_reg        <= '0;
            slot_lo_reg   <= '0;
            slot_hi_reg   <= '0;
            day_hi_reg    <= '0;
            day_c_reg     <= '0;
            slot_c_reg    <= '0;
            run_reg       <= '0;
            mask_reg      <= '0;
            res_err_reg   <= sbt_pkg::ERR_OK;
            out_err_reg   <= sbt_pkg::ERR_OK;
            out_day_reg   <= '0;
            out_mask_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sbt_pkg::REG_SLOTS_PER_DAY:
                        spd_reg <= sat_cfg(cfg_data, CW'(MAX_SLOTS_PER_DAY));
                    sbt_pkg::REG_DAYS_IN_USE:
                        days_reg <= sat_cfg(cfg_data, CW'(MAX_DAYS));
                    default:
                    begin
                    end
                endcase
            end

            // The emit state loads the output register itself.
            if (out_valid_reg && m_tready && state_reg != S_EMIT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        mode_reg    <= s_tuser;
                        id_reg      <= in_id;
                        cst_reg     <= in_cst;
                        cnt_reg     <= in_cnt;
                        s1_reg      <= in_s1;
                        res_err_reg <= in_err;
                        run_reg     <= '0;
                        mask_reg    <= '0;
                        if (in_err != sbt_pkg::ERR_OK)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            unique case (s_tuser)
                                sbt_pkg::MODE_FIND:
                                begin
                                    day_c_reg   <= in_day;
                                    day_hi_reg  <= in_eday - CW'(1);
                                    slot_c_reg  <= in_slot;
                                    slot_lo_reg <= in_slot;
                                    slot_hi_reg <= in_s1 + in_cnt - CW'(2);
                                    state_reg   <= S_FND_RD;
                                end
                                sbt_pkg::MODE_CLR_ID:
                                begin
                                    day_c_reg   <= '0;
                                    day_hi_reg  <= days_reg - CW'(1);
                                    slot_c_reg  <= '0;
                                    slot_lo_reg <= '0;
                                    slot_hi_reg <= spd_reg - CW'(1);
                                    state_reg   <= in_force ? S_WR_RD : S_CHK_RD;
                                end
                                default:
                                begin
                                    day_c_reg   <= in_day;
                                    day_hi_reg  <= in_day;
                                    slot_c_reg  <= in_slot;
                                    slot_lo_reg <= in_slot;
                                    slot_hi_reg <= in_slot + in_cnt - CW'(1);
                                    state_reg   <= in_force ? S_WR_RD : S_CHK_RD;
                                end
                            endcase
                        end
                    end
                end
                S_CHK_RD:
                begin
                    state_reg <= S_CHK_EV;
                end
                S_CHK_EV:
                begin
                    if (chk_fail)
                    begin
                        res_err_reg <= (mode_reg == sbt_pkg::MODE_RESERVE) ?
                                       sbt_pkg::ERR_NOT_FREE : sbt_pkg::ERR_NOT_BOOK;
                        state_reg   <= S_EMIT;
                    end
                    else if (walk_done)
                    begin
                        // Every check passed: rewind and commit.
                        day_c_reg  <= (mode_reg == sbt_pkg::MODE_CLR_ID) ? '0 : day_hi_reg;
                        slot_c_reg <= slot_lo_reg;
                        state_reg  <= S_WR_RD;
                    end
                    else
                    begin
                        if (slot_end)
                        begin
                            slot_c_reg <= slot_lo_reg;
                            day_c_reg  <= day_c_reg + CW'(1);
                        end
                        else
                        begin
                            slot_c_reg <= slot_c_reg + CW'(1);
                        end
                        state_reg <= S_CHK_RD;
                    end
                end
                S_WR_RD:
                begin
                    state_reg <= S_WR_EV;
                end
                S_WR_EV:
                begin
                    if (walk_done)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        if (slot_end)
                        begin
                            slot_c_reg <= slot_lo_reg;
                            day_c_reg  <= day_c_reg + CW'(1);
                        end
                        else
                        begin
                            slot_c_reg <= slot_c_reg + CW'(1);
                        end
                        state_reg <= S_WR_RD;
                    end
                end
                S_FND_RD:
                begin
                    state_reg <= S_FND_EV;
                end
                S_FND_EV:
                begin
                    // A run of cnt free slots ending here marks its start slot.
                    run_reg <= run_next;
                    if (run_next >= cnt_reg && start < s1_reg && start < CW'(32))
                        mask_reg <= mask_reg | (32'd1 << start[4:0]);
                    if (slot_end)
                        state_reg <= S_EMIT;
                    else
                    begin
                        slot_c_reg <= slot_c_reg + CW'(1);
                        state_reg  <= S_FND_RD;
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_err_reg   <= res_err_reg;
                        out_day_reg   <= find_ok ? day_c_reg[4:0] : 5'd0;
                        out_mask_reg  <= find_ok ? mask_reg : 32'd0;
                        out_last_reg  <= find_ok ? day_end : 1'b1;
                        if (find_ok && !day_end)
                        begin
                            day_c_reg  <= day_c_reg + CW'(1);
                            slot_c_reg <= slot_lo_reg;
                            run_reg    <= '0;
                            mask_reg   <= '0;
                            state_reg  <= S_FND_RD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_mask_reg, out_day_reg};
    assign m_tuser  = out_err_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    // One request at a time: after an accepted request the block is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while the previous one was still in work");

    // A failed request always ends its result sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != sbt_pkg::ERR_OK) |-> m_tlast)
        else $error("error result without last");

    // Day and mask are only reported by a successful find.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != sbt_pkg::ERR_OK) |-> (m_tdata == '0))
        else $error("error result carries day or mask data");
`endif

endmodule

FILE: dv/sbt_booking_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot booking table checker
// Mirrors the booking store from the accepted requests and compares every
// result the block returns against the mirrored outcome.
// ----------------------------------------------------------------------------
module sbt_booking_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [5:0]   cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [39:0]  m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         m_tlast,
    output int           fail_count,
    output int           results_owed
);

    localparam int NSLOT = sbt_pkg::DEF_MAX_SLOTS_PER_DAY;
    localparam int NDAY  = sbt_pkg::DEF_MAX_DAYS;

    typedef struct {
        logic [2:0]  err;
        logic [4:0]  day;
        logic [31:0] mask;
        logic        last;
    } booking_result_t;

    logic [sbt_pkg::STATUS_W-1:0] mirror_status [NDAY*NSLOT];
    logic [sbt_pkg::ID_W-1:0]     mirror_id     [NDAY*NSLOT];
    int                           slots_used;
    int                           days_used;
    booking_result_t              owed_results [$];

    function automatic int clamp_reg(logic [5:0] v, int hi);
        if (v == 0) return 1;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    function automatic bit slot_open(int idx);
        return mirror_status[idx] == sbt_pkg::ST_SCHEDULABLE ||
               mirror_status[idx] == sbt_pkg::ST_LOCKED;
    endfunction

    function automatic void owe(logic [2:0] e, int d, logic [31:0] m, bit l);
        booking_result_t r;
        r.err  = e;
        r.day  = d[4:0];
        r.mask = m;
        r.last = l;
        owed_results = {owed_results, r};
    endfunction

    function automatic logic [2:0] run_range_error(int d, int s, int c);
        if (s >= slots_used) return sbt_pkg::ERR_SLOT;
        if (c == 0 || s + c > slots_used) return sbt_pkg::ERR_COUNT;
        if (d >= days_used) return sbt_pkg::ERR_DAY;
        return sbt_pkg::ERR_OK;
    endfunction

    // Apply one request to the mirrored store and queue what it must return.
    function automatic void book_request(logic [1:0] mode, logic [103:0] td);
        int d, ed, s0, s1, c, base, idx;
        logic [sbt_pkg::ID_W-1:0] bid;
        logic [sbt_pkg::STATUS_W-1:0] cst;
        logic force_req;
        logic [2:0] e;
        logic [31:0] m;
        bit ok;
        d   = td[4:0];
        ed  = td[10:5];
        s0  = td[15:11];
        s1  = td[21:16];
        c   = td[27:22];
        bid = td[91:28];
        cst = td[99:92];
        force_req = td[100];
        e = sbt_pkg::ERR_OK;
        case (mode)
            sbt_pkg::MODE_FIND:
            begin
                if (c == 0 || c > slots_used) e = sbt_pkg::ERR_COUNT;
                else if (s0 + c > slots_used || s1 + c > slots_used) e = sbt_pkg::ERR_SLOT;
                else if (s0 + c > s1) e = sbt_pkg::ERR_COUNT;
                else if (ed > days_used || d >= ed) e = sbt_pkg::ERR_DAY;
                if (e != sbt_pkg::ERR_OK) begin
                    owe(e, 0, '0, 1'b1);
                    return;
                end
                for (int dd = d; dd < ed; dd++) begin
                    m = '0;
                    for (int s = s0; s < s1; s++) begin
                        ok = 1'b1;
                        for (int n = 0; n < c; n++)
                            if (!slot_open(dd*NSLOT + s + n)) ok = 1'b0;
                        if (ok) m[s] = 1'b1;
                    end
                    owe(sbt_pkg::ERR_OK, dd, m, dd + 1 == ed);
                end
                return;
            end
            sbt_pkg::MODE_RESERVE:
            begin
                e = run_range_error(d, s0, c);
                base = d*NSLOT + s0;
                if (e == sbt_pkg::ERR_OK && !force_req)
                    for (int i = 0; i < c; i++)
                        if (!slot_open(base + i)) e = sbt_pkg::ERR_NOT_FREE;
                if (e == sbt_pkg::ERR_OK)
                    for (int i = 0; i < c; i++) begin
                        mirror_status[base + i] = sbt_pkg::ST_BOOKED;
                        mirror_id[base + i]     = bid;
                    end
            end
            sbt_pkg::MODE_CLR_RNG:
            begin
                e = run_range_error(d, s0, c);
                base = d*NSLOT + s0;
                if (e == sbt_pkg::ERR_OK && !force_req)
                    for (int i = 0; i < c; i++)
                        if ((bid == 0 || bid == mirror_id[base + i]) &&
                            mirror_status[base + i] != sbt_pkg::ST_BOOKED)
                            e = sbt_pkg::ERR_NOT_BOOK;
                if (e == sbt_pkg::ERR_OK)
                    for (int i = 0; i < c; i++)
                        if (bid == 0 || bid == mirror_id[base + i]) begin
                            mirror_status[base + i] = cst;
                            mirror_id[base + i]     = '0;
                        end
            end
            default:
            begin
                if (bid == 0) e = sbt_pkg::ERR_ID_ZERO;
                // Check walk first, so a failure leaves the store untouched.
                if (e == sbt_pkg::ERR_OK && !force_req)
                    for (int dd = 0; dd < days_used; dd++)
                        for (int s = 0; s < slots_used; s++) begin
                            idx = dd*NSLOT + s;
                            if (mirror_id[idx] == bid &&
                                mirror_status[idx] != sbt_pkg::ST_BOOKED)
                                e = sbt_pkg::ERR_NOT_BOOK;
                        end
                if (e == sbt_pkg::ERR_OK)
                    for (int dd = 0; dd < days_used; dd++)
                        for (int s = 0; s < slots_used; s++) begin
                            idx = dd*NSLOT + s;
                            if (mirror_id[idx] == bid) begin
                                mirror_status[idx] = cst;
                                mirror_id[idx]     = '0;
                            end
                        end
            end
        endcase
        owe(e, 0, '0, 1'b1);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        booking_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < NDAY*NSLOT; i++) begin
                mirror_status[i] = sbt_pkg::ST_SCHEDULABLE;
                mirror_id[i]     = '0;
            end
            slots_used = NSLOT;
            days_used  = NDAY;
            owed_results.delete();
            fail_count   <= 0;
            results_owed <= 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == sbt_pkg::REG_SLOTS_PER_DAY)
                    slots_used = clamp_reg(cfg_data, NSLOT);
                else if (cfg_index == sbt_pkg::REG_DAYS_IN_USE)
                    days_used = clamp_reg(cfg_data, NDAY);
            end
            if (s_tvalid && s_tready)
                book_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result err=%0d day=%0d mask=%h last=%b",
                                 $realtime, m_tuser, m_tdata[4:0], m_tdata[36:5], m_tlast);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = owed_results.pop_front();
                    if (want.err !== m_tuser || want.day !== m_tdata[4:0] ||
                        want.mask !== m_tdata[36:5] || want.last !== m_tlast) begin
                        if (fail_count < 10)
                            $display("%0t: exp %0d/%0d/%h/%b got %0d/%0d/%h/%b",
                                     $realtime, want.err, want.day, want.mask, want.last,
                                     m_tuser, m_tdata[4:0], m_tdata[36:5], m_tlast);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            results_owed <= owed_results.size();
        end
    end

endmodule

FILE: dv/tb_slot_booking_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot booking table testbench
// Directed and random booking requests under several table shapes and
// handshake loads; a separate checker mirrors the store and scores results.
// ----------------------------------------------------------------------------
module tb_slot_booking_table;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [5:0]   cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    // s_tdata, from bit 0: day[5], end_day[6], slot[5], slot_end[6], count[6],
    // booking_id[64], clear_status[8], force_req[1], zero pad[3].
    logic [103:0] s_tdata;
    // s_tuser: mode[2].
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // m_tdata, from bit 0: found_day[5], free_mask[32], zero pad[3].
    logic [39:0]  m_tdata;
    // m_tuser: error[3].
    logic [2:0]   m_tuser;
    logic         m_tlast;

    int fail_count;
    int results_owed;

    // Percent chance per cycle that the sender holds back or the receiver stalls.
    int send_idle_pct;
    int recv_stall_pct;

    // Table shape currently programmed, used to aim the random requests.
    int slots_used;
    int days_used;

    slot_booking_table dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    sbt_booking_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .fail_count(fail_count), .results_owed(results_owed)
    );

    always #1 clk = ~clk;

    // The receiver decides its ready for the coming edge on each falling edge.
    always @(negedge clk)
        m_tready = ($urandom_range(99) >= recv_stall_pct);

    // Hard stop in case the block hangs. Worst case is far below this bound:
    // even full-table clears and 32-day finds under heavy stalls fit many times.
    initial begin
        #40000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Present one request and hold it until the block takes it.
    task automatic send_request(logic [1:0] mode, int d, int ed, int s0, int s1, int c,
                                logic [63:0] bid, logic [7:0] cst, bit force_req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tuser  = mode;
        s_tdata  = {3'b000, force_req, cst, bid, c[5:0], s1[5:0], s0[4:0], ed[5:0], d[4:0]};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Wait until every owed result has come back, then leave the block idle
    // for a while before the next phase.
    task automatic drain_results();
        @(negedge clk);
        while (results_owed != 0) @(negedge clk);
        repeat (4200) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [5:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        if (idx == sbt_pkg::REG_SLOTS_PER_DAY)
            slots_used = (val == 0) ? 1 : (val > 32) ? 32 : val;
        else
            days_used = (val == 0) ? 1 : (val > 32) ? 32 : val;
    endtask

    function automatic logic [63:0] pick_id();
        case ($urandom_range(9))
            0:       return 64'd0;
            1:       return 64'hFFFF_FFFF_FFFF_FFFF;
            2:       return {$urandom, $urandom};
            default: return 64'd1 + $urandom_range(4);
        endcase
    endfunction

    function automatic logic [7:0] pick_status();
        case ($urandom_range(4))
            0:       return sbt_pkg::ST_SCHEDULABLE;
            1:       return sbt_pkg::ST_LOCKED;
            2:       return sbt_pkg::ST_BOOKED;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed requests aimed at the current table shape, so that
    // reserves land and finds see a mix of booked and open slots. About one
    // in seven is raw noise over the full field widths.
    task automatic random_request();
        logic [1:0] mode;
        int d, ed, s0, s1, c, cmax;
        mode = $urandom_range(3);
        if ($urandom_range(6) == 0) begin
            send_request(mode, $urandom_range(31), $urandom_range(63), $urandom_range(31),
                         $urandom_range(63), $urandom_range(63), {$urandom, $urandom},
                         $urandom, $urandom_range(1));
            return;
        end
        d = $urandom_range(days_used - 1);
        if (mode == sbt_pkg::MODE_FIND) begin
            cmax = slots_used / 2;
            c  = (cmax < 1) ? 1 : $urandom_range(1, (cmax > 4) ? 4 : cmax);
            s0 = (slots_used >= 2*c) ? $urandom_range(0, slots_used - 2*c) : 0;
            s1 = (slots_used >= s0 + 2*c) ?
                 $urandom_range(s0 + c, slots_used - c) : s0 + c;
            ed = d + 1 + $urandom_range(2);
            if (ed > days_used) ed = days_used;
        end
        else begin
            cmax = ($urandom_range(4) == 0) ? slots_used : ((slots_used > 5) ? 5 : slots_used);
            c  = $urandom_range(1, cmax);
            s0 = $urandom_range(0, slots_used - c);
            s1 = $urandom_range(63);
            ed = $urandom_range(63);
        end
        send_request(mode, d, ed, s0, s1, c, pick_id(), pick_status(),
                     $urandom_range(99) < 15);
    endtask

    task automatic random_phase(int n, int hold_at);
        for (int i = 0; i < n; i++) begin
            // Let the pipe run completely dry once, mid-phase.
            if (i == hold_at) begin
                @(negedge clk);
                while (results_owed != 0) @(negedge clk);
            end
            random_request();
        end
        drain_results();
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = sbt_pkg::REG_SLOTS_PER_DAY;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = sbt_pkg::MODE_RESERVE;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        slots_used = 32;
        days_used = 32;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed part on the reset shape of 32 days by 32 slots.
        // A run that ends exactly on the last slot, with an all-ones id.
        send_request(sbt_pkg::MODE_RESERVE, 0, 0, 0, 0, 32, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 0);
        // Overlap on a booked slot is refused; forced, it goes through.
        send_request(sbt_pkg::MODE_RESERVE, 0, 0, 31, 0, 1, 64'd7, 8'h00, 0);
        send_request(sbt_pkg::MODE_RESERVE, 1, 0, 4, 0, 3, 64'd7, 8'h00, 0);
        send_request(sbt_pkg::MODE_RESERVE, 0, 0, 30, 0, 2, 64'd9, 8'h00, 1);
        // Range errors: run past the end, zero count; then the last day and slot, still in range.
        send_request(sbt_pkg::MODE_RESERVE, 31, 0, 31, 0, 2, 64'd5, 8'h00, 0);
        send_request(sbt_pkg::MODE_RESERVE, 31, 0, 0, 0, 0, 64'd5, 8'h00, 0);
        send_request(sbt_pkg::MODE_RESERVE, 31, 0, 31, 0, 1, 64'd5, 8'h00, 0);
        // Full sweep of every day: the most results one request can give.
        send_request(sbt_pkg::MODE_FIND, 0, 32, 0, 31, 1, 64'd0, 8'h00, 0);
        send_request(sbt_pkg::MODE_FIND, 0, 3, 0, 29, 3, 64'd0, 8'h00, 0);
        // Find errors: end slot plus count past the day, bad count,
        // start run overlapping end, empty and oversize day ranges.
        send_request(sbt_pkg::MODE_FIND, 0, 32, 0, 32, 1, 64'd0, 8'h00, 0);
        send_request(sbt_pkg::MODE_FIND, 0, 1, 0, 0, 33, 64'd0, 8'h00, 0);
        send_request(sbt_pkg::MODE_FIND, 0, 1, 5, 6, 2, 64'd0, 8'h00, 0);
        send_request(sbt_pkg::MODE_FIND, 4, 4, 0, 4, 1, 64'd0, 8'h00, 0);
        send_request(sbt_pkg::MODE_FIND, 0, 33, 0, 4, 1, 64'd0, 8'h00, 0);
        // Clear range: mismatching id leaves slots, wildcard id over open slots
        // is refused, forced wildcard releases the run with status code FF.
        send_request(sbt_pkg::MODE_CLR_RNG, 1, 0, 4, 0, 3, 64'd8, 8'h01, 0);
        send_request(sbt_pkg::MODE_CLR_RNG, 1, 0, 0, 0, 8, 64'd0, 8'h01, 0);
        send_request(sbt_pkg::MODE_CLR_RNG, 1, 0, 4, 0, 3, 64'd0, 8'hFF, 1);
        send_request(sbt_pkg::MODE_CLR_RNG, 0, 0, 30, 0, 2, 64'd9, 8'h00, 0);
        // Clear by id: zero id is refused, then an id rebooked by force and the all-ones id are cleared.
        send_request(sbt_pkg::MODE_CLR_ID, 0, 0, 0, 0, 1, 64'd0, 8'h00, 0);
        send_request(sbt_pkg::MODE_RESERVE, 2, 0, 0, 0, 2, 64'd11, 8'h00, 0);
        send_request(sbt_pkg::MODE_CLR_RNG, 2, 0, 0, 0, 1, 64'd11, 8'hAA, 1);
        send_request(sbt_pkg::MODE_RESERVE, 2, 0, 0, 0, 1, 64'd11, 8'h00, 1);
        send_request(sbt_pkg::MODE_CLR_ID, 0, 0, 0, 0, 1, 64'd11, 8'h55, 0);
        send_request(sbt_pkg::MODE_CLR_ID, 0, 0, 0, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 0);
        drain_results();

        // Narrow table, slow sender against a very sluggish receiver.
        send_idle_pct = 8;
        recv_stall_pct = 70;
        write_reg(sbt_pkg::REG_SLOTS_PER_DAY, 6'd8);
        write_reg(sbt_pkg::REG_DAYS_IN_USE, 6'd4);
        send_request(sbt_pkg::MODE_RESERVE, 0, 0, 8, 0, 1, 64'd1, 8'h00, 0);
        random_phase(130, 60);

        // Saturating extremes: zero gives one slot, oversize gives 32 days.
        write_reg(sbt_pkg::REG_SLOTS_PER_DAY, 6'd0);
        write_reg(sbt_pkg::REG_DAYS_IN_USE, 6'd63);
        random_phase(25, -1);

        // Full slots, two days, with the load roles swapped.
        send_idle_pct = 70;
        recv_stall_pct = 8;
        write_reg(sbt_pkg::REG_SLOTS_PER_DAY, 6'd63);
        write_reg(sbt_pkg::REG_DAYS_IN_USE, 6'd2);
        random_phase(125, 40);

        // Odd shape, no idling on either side.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(sbt_pkg::REG_SLOTS_PER_DAY, 6'd13);
        write_reg(sbt_pkg::REG_DAYS_IN_USE, 6'd32);
        random_phase(125, -1);

        if (fail_count == 0 && results_owed == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
